[hdl/rff_pkg.sv]
// Shared types and constants for the command frame builder.
// Holds the request, result, configuration and queue entry types.
// No dependencies.
package rff_pkg;

  // Request and result payloads.
  typedef struct packed {
    logic       mode;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       run_last;
    logic       frame_done;
    logic       no_open_frame;
  } out_res_t;

  // Request mode codes.
  localparam logic MODE_OPEN = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_START_BYTE  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_TYPE_FIRST  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_TYPE_SECOND = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_TYPE_THIRD  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_END_BYTE    = 3'd4;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] type_byte_first;
    logic [7:0] type_byte_second;
    logic [7:0] type_byte_third;
    logic [7:0] end_byte;
  } cfg_t;

  // Kinds of work the front hands to the back.
  typedef enum logic [1:0] {
    JOB_OPEN = 2'd0,
    JOB_DATA = 2'd1,
    JOB_ERR  = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;     // command for an open job, payload byte for a data job
    logic [7:0] length;
    logic       trailer;  // job closes the frame with check and end bytes
  } job_t;

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Step numbering inside one job.
  localparam logic [3:0] HDR_STEPS   = 4'd7;
  localparam logic [3:0] DATA_STEPS  = 4'd1;
  localparam logic [3:0] STEP_SEQ    = 4'd4;
  localparam logic [3:0] STEP_CMD    = 4'd5;
  localparam logic [3:0] STEP_LEN    = 4'd6;
  localparam logic [7:0] SEQ_BYTE    = 8'h00;
  localparam logic [7:0] SUM_INIT    = 8'hFF;
  localparam logic [8:0] SUM_MOD     = 9'd255;

endpackage

[hdl/rff_front.sv]
// Front end of the frame builder: accepts requests and classifies them.
// Tracks the open frame and remaining payload count; uses rff_pkg.
module rff_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  rff_pkg::in_req_t in_req,
  input  logic             q_full,
  output logic             push,
  output rff_pkg::job_t    job
);

  logic       frame_open;
  logic [7:0] remaining;
  logic       accept;
  logic       is_last_byte;

  assign in_stall     = q_full;
  assign accept       = in_valid && !q_full;
  assign push         = accept;
  assign is_last_byte = (remaining == 8'd1);

  // Classify the request into a job for the back end.
  always_comb begin
    job.data    = in_req.payload_byte;
    job.length  = in_req.payload_length;
    job.trailer = 1'b0;
    job.kind    = rff_pkg::JOB_ERR;
    if (in_req.mode == rff_pkg::MODE_OPEN) begin
      job.kind    = rff_pkg::JOB_OPEN;
      job.data    = in_req.command;
      job.trailer = (in_req.payload_length == 8'd0);
    end else if (frame_open) begin
      job.kind    = rff_pkg::JOB_DATA;
      job.trailer = is_last_byte;
    end
  end

  // Frame tracking; a data request with no open frame leaves it untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      remaining  <= 8'd0;
    end else if (accept) begin
      if (in_req.mode == rff_pkg::MODE_OPEN) begin
        frame_open <= (in_req.payload_length != 8'd0);
        remaining  <= in_req.payload_length;
      end else if (frame_open) begin
        remaining <= remaining - 8'd1;
        if (is_last_byte) begin
          frame_open <= 1'b0;
        end
      end
    end
  end

endmodule

[hdl/rff_queue.sv]
// Short job queue between the front and back ends of the frame builder.
// Register-based FIFO of rff_pkg::job_t entries.
module rff_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rff_pkg::job_t push_job,
  input  logic          pop,
  output rff_pkg::job_t head,
  output logic          empty,
  output logic          full
);

  rff_pkg::job_t                 entries [rff_pkg::QDEPTH];
  logic [rff_pkg::QAW-1:0]       wr_ptr;
  logic [rff_pkg::QAW-1:0]       rd_ptr;
  logic [rff_pkg::QCW-1:0]       count;

  assign empty = (count == '0);
  assign full  = (count == rff_pkg::QCW'(rff_pkg::QDEPTH));
  assign head  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rff_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + rff_pkg::QAW'(1);
      end
      if (push && !pop) begin
        count <= count + rff_pkg::QCW'(1);
      end else if (pop && !push) begin
        count <= count - rff_pkg::QCW'(1);
      end
    end
  end

endmodule

[hdl/rff_back.sv]
// Back end of the frame builder: expands jobs into frame bytes.
// Keeps the Fletcher-16 sums and the output register; uses rff_pkg.
module rff_back (
  input  logic              clk,
  input  logic              rst,
  input  rff_pkg::cfg_t     cfg,
  input  rff_pkg::job_t     head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output rff_pkg::out_res_t out_res
);

  logic [3:0] step;
  logic [7:0] sum_a;
  logic [7:0] sum_b;

  logic [3:0] base;
  logic       in_trailer;
  logic [3:0] tpos;
  logic [7:0] byte_sel;
  logic       summed;
  logic       last;
  logic       out_ready;
  logic       adv;
  logic [7:0] a_base;
  logic [7:0] b_base;
  logic [8:0] a_sum;
  logic [7:0] a_next;
  logic [8:0] b_sum;
  logic [7:0] b_next;

  assign out_ready = !out_valid || !out_stall;
  assign adv       = !empty && out_ready;
  assign pop       = adv && last;

  // Position of the current step within the job.
  always_comb begin
    base       = (head.kind == rff_pkg::JOB_OPEN) ? rff_pkg::HDR_STEPS : rff_pkg::DATA_STEPS;
    in_trailer = head.trailer && (step >= base);
    tpos       = step - base;
  end

  // Byte selection for the current step.
  always_comb begin
    byte_sel = 8'd0;
    summed   = 1'b0;
    last     = 1'b0;
    if (head.kind == rff_pkg::JOB_ERR) begin
      last = 1'b1;
    end else if (in_trailer) begin
      last = (tpos == 4'd2);
      unique case (tpos[1:0])
        2'd0:    byte_sel = sum_a;
        2'd1:    byte_sel = sum_b;
        default: byte_sel = cfg.end_byte;
      endcase
    end else begin
      summed = 1'b1;
      last   = !head.trailer && (step == base - 4'd1);
      if (head.kind == rff_pkg::JOB_OPEN) begin
        unique case (step)
          4'd0:              byte_sel = cfg.start_byte;
          4'd1:              byte_sel = cfg.type_byte_first;
          4'd2:              byte_sel = cfg.type_byte_second;
          4'd3:              byte_sel = cfg.type_byte_third;
          rff_pkg::STEP_SEQ: byte_sel = rff_pkg::SEQ_BYTE;
          rff_pkg::STEP_CMD: byte_sel = head.data;
          rff_pkg::STEP_LEN: byte_sel = head.length;
          default:           byte_sel = 8'd0;
        endcase
      end else begin
        byte_sel = head.data;
      end
    end
  end

  // Fletcher sums with end-around carry; an open job restarts them.
  always_comb begin
    if (head.kind == rff_pkg::JOB_OPEN && step == 4'd0) begin
      a_base = rff_pkg::SUM_INIT;
      b_base = rff_pkg::SUM_INIT;
    end else begin
      a_base = sum_a;
      b_base = sum_b;
    end
    a_sum  = {1'b0, a_base} + {1'b0, byte_sel};
    a_next = (a_sum > rff_pkg::SUM_MOD) ? 8'(a_sum - rff_pkg::SUM_MOD) : a_sum[7:0];
    b_sum  = {1'b0, b_base} + {1'b0, a_next};
    b_next = (b_sum > rff_pkg::SUM_MOD) ? 8'(b_sum - rff_pkg::SUM_MOD) : b_sum[7:0];
  end

  // Step counter and sum registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= 4'd0;
      sum_a <= rff_pkg::SUM_INIT;
      sum_b <= rff_pkg::SUM_INIT;
    end else if (adv) begin
      step <= last ? 4'd0 : step + 4'd1;
      if (summed) begin
        sum_a <= a_next;
        sum_b <= b_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res.frame_byte    <= byte_sel;
      out_res.run_last      <= last;
      out_res.frame_done    <= in_trailer && (tpos == 4'd2);
      out_res.no_open_frame <= (head.kind == rff_pkg::JOB_ERR);
    end
  end

  // Checks on the sequencer and sums.
  a_step_range: assert property (@(posedge clk) disable iff (rst) step <= 4'd9)
    else $error("step counter out of range");
  a_sum_nonzero: assert property (@(posedge clk) disable iff (rst)
    sum_a != 8'd0 && sum_b != 8'd0)
    else $error("Fletcher sum left its range");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.frame_done |-> out_res.run_last)
    else $error("end marker is not the last byte of its request");
  a_err_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.no_open_frame |-> out_res.run_last && out_res.frame_byte == 8'd0)
    else $error("bad no-open-frame result");

endmodule

[hdl/request_framer_fletcher16.sv]
// Top level of the command frame builder with Fletcher-16 check bytes.
// Holds the configuration registers; instantiates rff_front, rff_queue, rff_back.
//
//   Port group   Direction  Handshake           Payload
//   in_*         receive    in_valid/in_stall   rff_pkg::in_req_t
//   out_*        send       out_valid/out_stall rff_pkg::out_res_t
//   cfg_*        receive    cfg_en              cfg_index, cfg_data
//
// An open request yields 7 bytes, or 10 when its length is zero; a data
// request yields 1 byte, or 4 when it is the last of its frame.
// Requests are taken one per cycle until the 4-entry job queue fills.
// The back end sends one byte per cycle, unless out_stall holds it, through its
// single output register, so throughput is set by the result bytes per request.
// Reset is synchronous; configuration registers return to their defaults.
// Output stalls fill the queue, after which in_stall rises.
module request_framer_fletcher16 (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  rff_pkg::in_req_t         in_req,
  output logic                     out_valid,
  input  logic                     out_stall,
  output rff_pkg::out_res_t        out_res,
  input  logic                     cfg_en,
  input  logic [rff_pkg::CFG_IW-1:0] cfg_index,
  input  logic [7:0]               cfg_data
);

  rff_pkg::cfg_t cfg;
  rff_pkg::job_t push_job;
  rff_pkg::job_t head;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte       <= 8'h02;
      cfg.type_byte_first  <= 8'h54;
      cfg.type_byte_second <= 8'h53;
      cfg.type_byte_third  <= 8'h58;
      cfg.end_byte         <= 8'h03;
    end else if (cfg_en) begin
      unique case (cfg_index)
        rff_pkg::CFG_START_BYTE:  cfg.start_byte       <= cfg_data;
        rff_pkg::CFG_TYPE_FIRST:  cfg.type_byte_first  <= cfg_data;
        rff_pkg::CFG_TYPE_SECOND: cfg.type_byte_second <= cfg_data;
        rff_pkg::CFG_TYPE_THIRD:  cfg.type_byte_third  <= cfg_data;
        rff_pkg::CFG_END_BYTE:    cfg.end_byte         <= cfg_data;
        default: ;
      endcase
    end
  end

  rff_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  rff_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  rff_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule
